// ===== hw/rtl/plim_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plim_pkg
// Shared types and constants of the per-host connection limiter: table entry
// layout, response status codes, controller states and limit settings.
// ----------------------------------------------------------------------------
package plim_pkg;

  localparam int unsigned TableEntriesDefault = 64;
  localparam int unsigned CntWidth = 16;
  localparam int unsigned AddrWordWidth = 64;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [CntWidth-1:0] CntMax = {CntWidth{1'b1}};
  localparam logic [CntWidth-1:0] MaxTotalReset = 16'd100;
  localparam logic [CntWidth-1:0] MaxPerSourceReset = 16'd4;
  localparam logic [AddrWordWidth-1:0] Ipv4Loopback = 64'h0000_0000_7F00_0001;
  localparam logic [AddrWordWidth-1:0] Ipv6LoopbackLower = 64'd1;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_MAX_TOTAL      = 2'd0,
    CFG_MAX_PER_SOURCE = 2'd1
  } cfg_index_t;

  typedef enum logic {
    CMD_CONNECT    = 1'b0,
    CMD_DISCONNECT = 1'b1
  } cmd_t;

  typedef enum logic {
    FAM_IPV4 = 1'b0,
    FAM_IPV6 = 1'b1
  } family_t;

  typedef enum logic [2:0] {
    STAT_ACCEPTED    = 3'd0,
    STAT_TOTAL_LIMIT = 3'd1,
    STAT_HOST_LIMIT  = 3'd2,
    STAT_TABLE_FULL  = 3'd3,
    STAT_RELEASED    = 3'd4,
    STAT_NOT_FOUND   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic                     valid;
    logic                     family;
    logic [AddrWordWidth-1:0] upper;
    logic [AddrWordWidth-1:0] lower;
    logic [CntWidth-1:0]      count;
  } entry_t;

  typedef struct packed {
    logic [CntWidth-1:0] max_total;
    logic [CntWidth-1:0] max_per_source;
  } limits_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plim_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plim_table
// Source table memory: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module plim_table
  import plim_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/plim_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plim_ctrl
// Request sequencer: clears the table after reset, walks the table for a
// matching source and the first free slot, applies the limits, writes the
// updated entry back and issues the response.
// ----------------------------------------------------------------------------
module plim_ctrl
  import plim_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire limits_t                  limits,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_cmd,
  input  wire logic                     in_family,
  input  wire logic [AddrWordWidth-1:0] in_addr_upper,
  input  wire logic [AddrWordWidth-1:0] in_addr_lower,
  output logic                          out_valid,
  output status_t                       out_status,
  output logic [CntWidth-1:0]           out_source_count,
  output logic [CntWidth-1:0]           out_total_count,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output entry_t                        wr_data,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  wire entry_t                   rd_data
);

  localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] EndIssue = CW'(TABLE_ENTRIES);

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            clr_idx_r, clr_idx_nxt;
  logic [CW-1:0]            issue_r, issue_nxt;
  logic [AW-1:0]            chk_idx_r, chk_idx_nxt;
  logic                     req_cmd_r, req_cmd_nxt;
  logic                     req_fam_r, req_fam_nxt;
  logic [AddrWordWidth-1:0] req_up_r, req_up_nxt;
  logic [AddrWordWidth-1:0] req_lo_r, req_lo_nxt;
  logic                     found_r, found_nxt;
  logic [AW-1:0]            found_idx_r, found_idx_nxt;
  logic [CntWidth-1:0]      found_cnt_r, found_cnt_nxt;
  logic                     free_r, free_nxt;
  logic [AW-1:0]            free_idx_r, free_idx_nxt;
  logic [CntWidth-1:0]      total_r, total_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [CntWidth-1:0]      out_src_r, out_src_nxt;
  logic [CntWidth-1:0]      out_total_r, out_total_nxt;

  logic                     hit;
  logic                     is_local;
  logic [CntWidth-1:0]      dec_cnt;

  assign hit = rd_data.valid && (rd_data.family == req_fam_r) &&
               (rd_data.upper == req_up_r) && (rd_data.lower == req_lo_r);

  assign is_local = (req_fam_r == FAM_IPV4) ? (req_lo_r == Ipv4Loopback) :
                    ((req_up_r == '0) && (req_lo_r == Ipv6LoopbackLower));

  assign dec_cnt = (found_cnt_r != '0) ? found_cnt_r - 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_r      <= issue_nxt;
    chk_idx_r    <= chk_idx_nxt;
    req_cmd_r    <= req_cmd_nxt;
    req_fam_r    <= req_fam_nxt;
    req_up_r     <= req_up_nxt;
    req_lo_r     <= req_lo_nxt;
    found_r      <= found_nxt;
    found_idx_r  <= found_idx_nxt;
    found_cnt_r  <= found_cnt_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_src_r    <= out_src_nxt;
    out_total_r  <= out_total_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    issue_nxt      = issue_r;
    chk_idx_nxt    = chk_idx_r;
    req_cmd_nxt    = req_cmd_r;
    req_fam_nxt    = req_fam_r;
    req_up_nxt     = req_up_r;
    req_lo_nxt     = req_lo_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    found_cnt_nxt  = found_cnt_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    total_nxt      = total_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_src_nxt    = out_src_r;
    out_total_nxt  = out_total_r;
    busy           = 1'b1;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        if (clr_idx_r == LastIdx) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end

      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          req_cmd_nxt = in_cmd;
          req_fam_nxt = in_family;
          if (in_family == FAM_IPV4) begin
            req_up_nxt = '0;
            req_lo_nxt = {32'd0, in_addr_lower[31:0]};
          end else begin
            req_up_nxt = in_addr_upper;
            req_lo_nxt = in_addr_lower;
          end
          found_nxt   = 1'b0;
          free_nxt    = 1'b0;
          rd_en       = 1'b1;
          rd_addr     = '0;
          chk_idx_nxt = '0;
          issue_nxt   = CW'(1);
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (hit) begin
          found_nxt     = 1'b1;
          found_idx_nxt = chk_idx_r;
          found_cnt_nxt = rd_data.count;
          state_nxt     = ST_DECIDE;
        end else begin
          if (!rd_data.valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (issue_r == EndIssue) begin
            state_nxt = ST_DECIDE;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = issue_r[AW-1:0];
            chk_idx_nxt = issue_r[AW-1:0];
            issue_nxt   = CW'(issue_r + 1'b1);
          end
        end
      end

      ST_DECIDE: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_src_nxt   = '0;
        wr_data.family = req_fam_r;
        wr_data.upper  = req_up_r;
        wr_data.lower  = req_lo_r;
        if (req_cmd_r == CMD_CONNECT) begin
          if ((total_r == CntMax) || (!is_local && (total_r >= limits.max_total))) begin
            out_status_nxt = STAT_TOTAL_LIMIT;
            if (found_r) begin
              out_src_nxt = found_cnt_r;
            end
          end else if (found_r) begin
            if ((found_cnt_r == CntMax) ||
                (!is_local && (found_cnt_r >= limits.max_per_source))) begin
              out_status_nxt = STAT_HOST_LIMIT;
              out_src_nxt    = found_cnt_r;
            end else begin
              out_status_nxt = STAT_ACCEPTED;
              out_src_nxt    = found_cnt_r + 1'b1;
              total_nxt      = total_r + 1'b1;
              wr_en          = 1'b1;
              wr_addr        = found_idx_r;
              wr_data.valid  = 1'b1;
              wr_data.count  = found_cnt_r + 1'b1;
            end
          end else if (free_r) begin
            out_status_nxt = STAT_ACCEPTED;
            out_src_nxt    = CntWidth'(1);
            total_nxt      = total_r + 1'b1;
            wr_en          = 1'b1;
            wr_addr        = free_idx_r;
            wr_data.valid  = 1'b1;
            wr_data.count  = CntWidth'(1);
          end else begin
            out_status_nxt = STAT_TABLE_FULL;
          end
        end else begin
          if (found_r) begin
            out_status_nxt = STAT_RELEASED;
            out_src_nxt    = dec_cnt;
            if (total_r != '0) begin
              total_nxt = total_r - 1'b1;
            end
            wr_en         = 1'b1;
            wr_addr       = found_idx_r;
            wr_data.valid = (dec_cnt != '0);
            wr_data.count = dec_cnt;
          end else begin
            out_status_nxt = STAT_NOT_FOUND;
          end
        end
        out_total_nxt = total_nxt;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_source_count = out_src_r;
  assign out_total_count  = out_total_r;

endmodule

`default_nettype wire

// ===== hw/rtl/per_host_connection_limiter.sv =====
`default_nettype none
// Timing: a result strobe follows an accepted request after a table walk that reads one
// entry at a time from the single read port and stops at the first matching entry.
// A new request is taken only while busy is low; busy drops with the strobe.
// Reset: after rst_n rises the table is cleared with busy high;
// configuration writes are taken at any time. Results cannot be stalled.
// ----------------------------------------------------------------------------
// per_host_connection_limiter
// Counts open connections per IPv4 or IPv6 source and enforces global and
// per-source limits, with loopback sources exempt from both limits.
// ----------------------------------------------------------------------------
module per_host_connection_limiter
  import plim_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_cmd,
  input  wire logic                     in_family,
  input  wire logic [AddrWordWidth-1:0] in_addr_upper,
  input  wire logic [AddrWordWidth-1:0] in_addr_lower,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [CntWidth-1:0]           out_source_count,
  output logic [CntWidth-1:0]           out_total_count,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CntWidth-1:0]      cfg_data
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  limits_t       limits_r, limits_nxt;
  status_t       status;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    limits_nxt = limits_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_TOTAL:      limits_nxt.max_total = cfg_data;
        CFG_MAX_PER_SOURCE: limits_nxt.max_per_source = cfg_data;
        default:            limits_nxt = limits_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.max_total      <= MaxTotalReset;
      limits_r.max_per_source <= MaxPerSourceReset;
    end else begin
      limits_r <= limits_nxt;
    end
  end

  plim_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .limits          (limits_r),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_family       (in_family),
    .in_addr_upper   (in_addr_upper),
    .in_addr_lower   (in_addr_lower),
    .out_valid       (out_valid),
    .out_status      (status),
    .out_source_count(out_source_count),
    .out_total_count (out_total_count),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  plim_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_status = status;

`ifndef NO_ASSERTIONS
  a_take_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a request is still in progress");

  a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STAT_ACCEPTED) |->
      (out_source_count != '0) && (out_total_count != '0))
    else $error("accepted connection reported with a zero count");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((status == STAT_NOT_FOUND) || (status == STAT_TABLE_FULL)) |->
      (out_source_count == '0))
    else $error("unknown source reported with a nonzero count");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-host connection limiter. Connect and
// disconnect requests go in one at a time on the start/busy handshake while a
// shadow copy of the connection table predicts each response; every strobed
// response is checked against the oldest prediction. Directed tests cover
// limits, loopback exemption, address matching and a full table, and random
// traffic over small host pools runs under several limit settings.
// ----------------------------------------------------------------------------
module testbench;
  import plim_pkg::*;

  localparam int TableSize = TableEntriesDefault;
  localparam int WatchdogLimit = 2000;
  localparam int CfgIndexFirstSpare = int'(CFG_MAX_PER_SOURCE) + 1;
  localparam int CfgIndexLast = (1 << CfgIndexWidth) - 1;

  typedef struct packed {
    cmd_t                     cmd;
    family_t                  family;
    logic [AddrWordWidth-1:0] upper;
    logic [AddrWordWidth-1:0] lower;
  } request_t;

  typedef struct packed {
    status_t             status;
    logic [CntWidth-1:0] source;
    logic [CntWidth-1:0] total;
  } reply_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_cmd = 1'b0;
  logic                     in_family = 1'b0;
  logic [AddrWordWidth-1:0] in_addr_upper = '0;
  logic [AddrWordWidth-1:0] in_addr_lower = '0;
  logic                     out_valid;
  logic [2:0]               out_status;
  logic [CntWidth-1:0]      out_source_count;
  logic [CntWidth-1:0]      out_total_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CntWidth-1:0]      cfg_data = '0;

  logic                     tbl_valid [TableSize];
  logic                     tbl_family [TableSize];
  logic [AddrWordWidth-1:0] tbl_upper [TableSize];
  logic [AddrWordWidth-1:0] tbl_lower [TableSize];
  logic [CntWidth-1:0]      tbl_count [TableSize];
  logic [CntWidth-1:0]      open_total = '0;
  logic [CntWidth-1:0]      limit_total = MaxTotalReset;
  logic [CntWidth-1:0]      limit_per_source = MaxPerSourceReset;

  reply_t pending_replies[$];
  int     mismatch_count = 0;
  int     reply_index = 0;
  int     stall_cycles = 0;
  bit     sender_idles = 1'b1;

  per_host_connection_limiter #(
    .TABLE_ENTRIES(TableSize)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_family        (in_family),
    .in_addr_upper    (in_addr_upper),
    .in_addr_lower    (in_addr_lower),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_source_count (out_source_count),
    .out_total_count  (out_total_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Updates the shadow table for one request and returns the response it must give.
  function automatic reply_t apply_request(input request_t req);
    reply_t                   r;
    int                       slot;
    int                       free_slot;
    logic                     exempt;
    logic [AddrWordWidth-1:0] up;
    logic [AddrWordWidth-1:0] lo;
    up = req.upper;
    lo = req.lower;
    if (req.family == FAM_IPV4) begin
      up = '0;
      lo[63:32] = '0;
      exempt = (lo == Ipv4Loopback);
    end else begin
      exempt = (up == '0) && (lo == Ipv6LoopbackLower);
    end
    slot = -1;
    for (int i = 0; i < TableSize; i++) begin
      if (slot < 0 && tbl_valid[i] && tbl_family[i] == req.family &&
          tbl_upper[i] == up && tbl_lower[i] == lo) begin
        slot = i;
      end
    end
    r.source = '0;
    if (req.cmd == CMD_CONNECT) begin
      if (open_total == CntMax || (!exempt && open_total >= limit_total)) begin
        r.status = STAT_TOTAL_LIMIT;
        if (slot >= 0) r.source = tbl_count[slot];
      end else if (slot >= 0) begin
        r.source = tbl_count[slot];
        if (r.source == CntMax || (!exempt && r.source >= limit_per_source)) begin
          r.status = STAT_HOST_LIMIT;
        end else begin
          r.source = r.source + 1'b1;
          tbl_count[slot] = r.source;
          open_total = open_total + 1'b1;
          r.status = STAT_ACCEPTED;
        end
      end else begin
        free_slot = -1;
        for (int i = 0; i < TableSize; i++) begin
          if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          r.status = STAT_TABLE_FULL;
        end else begin
          tbl_valid[free_slot] = 1'b1;
          tbl_family[free_slot] = req.family;
          tbl_upper[free_slot] = up;
          tbl_lower[free_slot] = lo;
          tbl_count[free_slot] = CntWidth'(1);
          r.source = CntWidth'(1);
          open_total = open_total + 1'b1;
          r.status = STAT_ACCEPTED;
        end
      end
    end else if (slot >= 0) begin
      r.source = tbl_count[slot];
      if (r.source != '0) r.source = r.source - 1'b1;
      tbl_count[slot] = r.source;
      if (open_total != '0) open_total = open_total - 1'b1;
      if (r.source == '0) tbl_valid[slot] = 1'b0;
      r.status = STAT_RELEASED;
    end else begin
      r.status = STAT_NOT_FOUND;
    end
    r.total = open_total;
    return r;
  endfunction

  function automatic request_t random_address();
    request_t r;
    r.cmd = CMD_CONNECT;
    r.family = family_t'($urandom_range(0, 1));
    r.upper = rand64();
    r.lower = rand64();
    if (r.family == FAM_IPV4) begin
      r.upper = '0;
      r.lower[63:32] = '0;
    end
    return r;
  endfunction

  function automatic request_t pool_host();
    request_t r;
    r = random_address();
    case ($urandom_range(0, 9))
      0: r = '{CMD_CONNECT, FAM_IPV4, '0, Ipv4Loopback};
      1: r = '{CMD_CONNECT, FAM_IPV6, '0, Ipv6LoopbackLower};
      2: begin
        r.family = FAM_IPV6;
        r.upper = '0;
        r.lower[63:32] = '0;
      end
      3: begin
        r.family = FAM_IPV6;
        r.upper = rand64();
        r.lower = Ipv6LoopbackLower;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", what);
  endtask

  task automatic send_request(input request_t req);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_cmd <= req.cmd;
    in_family <= req.family;
    in_addr_upper <= req.upper;
    in_addr_lower <= req.lower;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_replies.insert(pending_replies.size(), apply_request(req));
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic cfg_push(input logic [CfgIndexWidth-1:0] idx,
                          input logic [CntWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_TOTAL: limit_total = data;
      CFG_MAX_PER_SOURCE: limit_per_source = data;
      default: ;
    endcase
  endtask

  task automatic program_limits(input logic [CntWidth-1:0] total,
                                input logic [CntWidth-1:0] per_src, input bit spare);
    if ($urandom_range(0, 1) == 1) begin
      cfg_push(CFG_MAX_TOTAL, total);
      cfg_push(CFG_MAX_PER_SOURCE, per_src);
    end else begin
      cfg_push(CFG_MAX_PER_SOURCE, per_src);
      cfg_push(CFG_MAX_TOTAL, total);
    end
    if (spare) begin
      cfg_push(CfgIndexWidth'($urandom_range(CfgIndexFirstSpare, CfgIndexLast)),
               CntWidth'($urandom_range(0, CntMax)));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_limits();
    request_t host;
    host = '{CMD_CONNECT, FAM_IPV4, '0, {32'h0, 1'b1, 31'($urandom)}};
    repeat (5) send_request(host);
    host.cmd = CMD_DISCONNECT;
    repeat (5) send_request(host);
    drain_requests();
  endtask

  task automatic test_address_match();
    request_t v4;
    request_t twin;
    request_t v6;
    v4 = '{CMD_CONNECT, FAM_IPV4, rand64(), {$urandom, 1'b1, 31'($urandom)}};
    send_request(v4);
    twin = '{CMD_CONNECT, FAM_IPV6, '0, {32'h0, v4.lower[31:0]}};
    send_request(twin);
    v4.cmd = CMD_DISCONNECT;
    v4.upper = rand64();
    v4.lower[63:32] = $urandom;
    send_request(v4);
    twin.cmd = CMD_DISCONNECT;
    send_request(twin);
    v6 = '{CMD_CONNECT, FAM_IPV6, rand64(), rand64()};
    send_request(v6);
    v6.cmd = CMD_DISCONNECT;
    v6.lower[0] = ~v6.lower[0];
    send_request(v6);
    v6.lower[0] = ~v6.lower[0];
    v6.upper[63] = ~v6.upper[63];
    send_request(v6);
    v6.upper[63] = ~v6.upper[63];
    send_request(v6);
    drain_requests();
  endtask

  task automatic test_loopback_exempt();
    request_t lo4;
    request_t lo6;
    request_t near;
    program_limits('0, '0, 1'b1);
    lo4 = '{CMD_CONNECT, FAM_IPV4, rand64(), {$urandom, Ipv4Loopback[31:0]}};
    send_request(lo4);
    lo6 = '{CMD_CONNECT, FAM_IPV6, '0, Ipv6LoopbackLower};
    send_request(lo6);
    near = '{CMD_CONNECT, FAM_IPV6, 64'h1 << $urandom_range(0, 63), Ipv6LoopbackLower};
    send_request(near);
    near = '{CMD_CONNECT, FAM_IPV6, '0, Ipv4Loopback};
    send_request(near);
    lo4.cmd = CMD_DISCONNECT;
    lo4.upper = rand64();
    send_request(lo4);
    lo6.cmd = CMD_DISCONNECT;
    send_request(lo6);
    drain_requests();
  endtask

  task automatic test_new_source_zero_limit();
    request_t host;
    program_limits(CntMax, '0, 1'b0);
    host = '{CMD_CONNECT, FAM_IPV6, rand64() | 64'h1, rand64()};
    send_request(host);
    send_request(host);
    host.cmd = CMD_DISCONNECT;
    send_request(host);
    drain_requests();
  endtask

  task automatic test_table_full();
    request_t hosts[$];
    request_t extra;
    int       victim;
    program_limits(CntMax, CntMax, 1'b1);
    repeat (TableSize) hosts.insert(hosts.size(), random_address());
    foreach (hosts[i]) send_request(hosts[i]);
    extra = random_address();
    send_request(extra);
    victim = $urandom_range(0, TableSize - 1);
    hosts[victim].cmd = CMD_DISCONNECT;
    send_request(hosts[victim]);
    send_request(extra);
    hosts[victim] = extra;
    foreach (hosts[i]) begin
      hosts[i].cmd = CMD_DISCONNECT;
      send_request(hosts[i]);
    end
    drain_requests();
  endtask

  task automatic test_random_traffic(input logic [CntWidth-1:0] total,
                                     input logic [CntWidth-1:0] per_src,
                                     input int pool_size, input int n_items,
                                     input int connect_pct);
    request_t pool[$];
    request_t req;
    program_limits(total, per_src, bit'($urandom_range(0, 1)));
    repeat (pool_size) pool.insert(pool.size(), pool_host());
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 8) begin
        req = '{CMD_CONNECT, family_t'($urandom_range(0, 1)), rand64(), rand64()};
      end else begin
        req = pool[$urandom_range(0, pool.size() - 1)];
        if (req.family == FAM_IPV4) begin
          if ($urandom_range(0, 1) == 1) req.upper = rand64();
          if ($urandom_range(0, 1) == 1) req.lower[63:32] = $urandom;
        end
      end
      req.cmd = ($urandom_range(0, 99) < connect_pct) ? CMD_CONNECT : CMD_DISCONNECT;
      send_request(req);
    end
    drain_requests();
  endtask

  always @(posedge clk) begin : check_reply
    reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        note_mismatch($sformatf("unexpected response: status %0d source %0d total %0d",
                                out_status, out_source_count, out_total_count));
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status || out_source_count !== want.source ||
            out_total_count !== want.total) begin
          note_mismatch($sformatf(
              "response %0d: status %0d/%0d source %0d/%0d total %0d/%0d (exp/got)",
              reply_index, want.status, out_status, want.source, out_source_count,
              want.total, out_total_count));
        end
      end
      reply_index++;
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("per_host_connection_limiter regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TableSize; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_family[i] = 1'b0;
      tbl_upper[i] = '0;
      tbl_lower[i] = '0;
      tbl_count[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_default_limits();
    test_address_match();
    test_loopback_exempt();
    test_new_source_zero_limit();
    test_table_full();
    test_random_traffic('0, '0, 10, 150, 60);
    test_random_traffic(CntMax, CntMax, 80, 200, 75);
    test_random_traffic(MaxTotalReset, MaxPerSourceReset, 16, 150, 55);
    test_random_traffic(CntWidth'($urandom_range(1, 40)), CntWidth'($urandom_range(1, 8)),
                        24, 150, 55);
    test_random_traffic(CntWidth'($urandom_range(0, CntMax)),
                        CntWidth'($urandom_range(0, CntMax)), 40, 150, 60);
    test_random_traffic(CntMax, CntWidth'(1), 30, 100, 50);
    sender_idles = 1'b0;
    test_random_traffic(CntWidth'($urandom_range(1, 60)), CntWidth'($urandom_range(1, 6)),
                        20, 100, 55);
    repeat (TableSize + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("per_host_connection_limiter regression: pass");
    end else begin
      $display("per_host_connection_limiter regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/plim_pkg.sv
hw/rtl/plim_table.sv
hw/rtl/plim_ctrl.sv
hw/rtl/per_host_connection_limiter.sv
sim/testbench.sv
